/* hw/rtl/nuclear_mass_cache_defines.svh */
// Assertion macros for the nuclear mass cache.
`ifndef NUCLEAR_MASS_CACHE_DEFINES_SVH
`define NUCLEAR_MASS_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define NMC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define NMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/nmc_pkg.sv */
// Package: constants, types and liquid-drop ROM tables for the nuclear mass cache.
package nmc_pkg;

   localparam int MAX_MASS_NUMBER_DEF    = 255;
   localparam int MASS_FRACTION_BITS_DEF = 16;

   localparam int MASS_W    = 47;
   localparam int ENTRY_W   = MASS_W + 2;
   localparam int STABLE_B  = MASS_W;
   localparam int CACHED_B  = MASS_W + 1;
   localparam int Q_W       = 64;
   localparam int DIV_W     = 22;
   localparam int CR_W      = 21;

   localparam logic [DIV_W-1:0] SURF_DIV  = DIV_W'(400);

   // (q << 19) / 78125 as (q * ceil(2^80 / 78125)) >> 61, exact for q < 2^44
   localparam logic [127:0] COUL_RCP_FULL = ((128'd1 << 80) + 128'd78124) / 128'd78125;
   localparam logic [63:0]  COUL_RCP      = COUL_RCP_FULL[63:0];
   localparam int           COUL_SH       = 61;

   typedef enum logic [1:0] {
      CMD_MASS = 2'd0,
      CMD_STAB = 2'd1,
      CMD_ADD  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic run;
      logic done;
   } div_stat_type;

   typedef logic [Q_W-1:0] tab_type [256];

   localparam logic [63:0] NEUTRON_Q32  = (64'd807132 << 32) / 64'd100000;
   localparam logic [63:0] HYDROGEN_Q32 = (64'd728897 << 32) / 64'd100000;
   localparam logic [63:0] AMU_Q32      = (64'd931494028 << 32) / 64'd1000000;
   localparam logic [63:0] ELECTRON_Q32 = (64'd510998910 << 32) / 64'd1000000000;

   function automatic logic [63:0] isqrt64(input logic [63:0] x_arg);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = x_arg;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (b > x) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] icbrt64(input logic [63:0] x_arg);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] b;
      x = x_arg;
      y = '0;
      for (int s = 63; s >= 0; s -= 3) begin
         y = y << 1;
         b = 64'd3 * y * (y + 64'd1) + 64'd1;
         if ((x >> s) >= b) begin
            x = x - (b << s);
            y = y + 64'd1;
         end
      end
      return y;
   endfunction

   // floor(n / d), shift and subtract
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // returns {exponent, mantissa Q30} packed as ex << 40 | r
   function automatic logic [63:0] zpow(input logic [31:0] z, input logic [63:0] e100);
      logic [31:0] m;
      logic [63:0] x;
      logic [63:0] frac;
      logic [63:0] p;
      logic [63:0] f;
      logic [63:0] r;
      logic [63:0] t;
      logic [63:0] ex;
      m = '0;
      frac = '0;
      for (int i = 0; i < 31; i++) begin
         if ((z >> (m + 1)) != 0) m = m + 1;
      end
      x = 64'(z) << (30 - m);
      for (int i = 0; i < 30; i++) begin
         x = (x * x) >> 30;
         frac = frac << 1;
         if (x >= (64'd2 << 30)) begin
            x = x >> 1;
            frac = frac | 64'd1;
         end
      end
      p = ((64'(m) << 30) | frac) * e100 / 64'd100;
      ex = p >> 30;
      f = p & ((64'd1 << 30) - 64'd1);
      r = 64'd1 << 30;
      t = isqrt64(64'd2 << 60);
      for (int k = 1; k <= 30; k++) begin
         if (((f >> (30 - k)) & 64'd1) != 0) r = (r * t) >> 30;
         t = isqrt64(t << 30);
      end
      return (ex << 40) | r;
   endfunction

   function automatic logic [63:0] zterm(input int z);
      logic [63:0] w;
      logic [63:0] r;
      logic [63:0] ex;
      logic [63:0] u;
      logic [63:0] acc;
      acc = '0;
      if (z != 0) begin
         w = zpow(32'(z), 64'd239);
         r = w & ((64'd1 << 40) - 64'd1);
         ex = w >> 40;
         u = ((64'd144381 * r) << 12) / 64'd9765625;
         acc = u >> (64'd20 - ex);
         w = zpow(32'(z), 64'd535);
         r = w & ((64'd1 << 40) - 64'd1);
         ex = w >> 40;
         u = ((64'd155468 * r) << 14) / 64'd762939453125;
         if (ex >= 64'd29) acc = acc + (u << (ex - 64'd29));
         else acc = acc + (u >> (64'd29 - ex));
      end
      return acc;
   endfunction

   function automatic tab_type pos_a_table();
      tab_type t;
      logic [63:0] cr;
      for (int a = 0; a < 256; a++) begin
         cr = icbrt64(64'(a) << 54);
         t[a] = 64'(a) * AMU_Q32 + (cr * cr * 64'd1723) / 64'd1600;
      end
      return t;
   endfunction

   function automatic tab_type neg_a_table();
      tab_type t;
      for (int a = 0; a < 256; a++) t[a] = ((64'(a) * 64'd1567) << 32) / 64'd100;
      return t;
   endfunction

   function automatic tab_type cr_a_table();
      tab_type t;
      for (int a = 0; a < 256; a++) t[a] = icbrt64(64'(a) << 54);
      return t;
   endfunction

   function automatic tab_type pair_a_table();
      tab_type t;
      logic [63:0] sr;
      for (int a = 0; a < 256; a++) begin
         sr = isqrt64(64'(a) << 54);
         t[a] = (sr == 0) ? 64'd0 : udiv64(64'd12 << 59, sr);
      end
      return t;
   endfunction

   function automatic tab_type pos_n_table();
      tab_type t;
      for (int n = 0; n < 256; n++) t[n] = 64'(n) * NEUTRON_Q32;
      return t;
   endfunction

   function automatic tab_type pos_z_table();
      tab_type t;
      for (int z = 0; z < 256; z++) t[z] = 64'(z) * HYDROGEN_Q32 + zterm(z);
      return t;
   endfunction

   function automatic tab_type neg_z_table();
      tab_type t;
      for (int z = 0; z < 256; z++) t[z] = 64'(z) * ELECTRON_Q32;
      return t;
   endfunction

   function automatic tab_type num_z_table();
      tab_type t;
      for (int z = 0; z < 256; z++) t[z] = 64'(z) * 64'(z) * 64'd6984523;
      return t;
   endfunction

   function automatic tab_type dd_table();
      tab_type t;
      for (int d = 0; d < 256; d++) t[d] = 64'(d) * 64'(d) * 64'd9315;
      return t;
   endfunction

   localparam tab_type POS_A_TAB  = pos_a_table();
   localparam tab_type NEG_A_TAB  = neg_a_table();
   localparam tab_type CR_A_TAB   = cr_a_table();
   localparam tab_type PAIR_A_TAB = pair_a_table();
   localparam tab_type POS_N_TAB  = pos_n_table();
   localparam tab_type POS_Z_TAB  = pos_z_table();
   localparam tab_type NEG_Z_TAB  = neg_z_table();
   localparam tab_type NUM_Z_TAB  = num_z_table();
   localparam tab_type DD_TAB     = dd_table();

endpackage

/* hw/rtl/nmc_ram.sv */
// Generic single-port-write, registered-read RAM.
module nmc_ram #(
   parameter int WIDTH = nmc_pkg::ENTRY_W,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/nmc_div.sv */
// Restoring divider, one quotient bit per cycle.
module nmc_div #(
   parameter int NUM_W = nmc_pkg::Q_W,
   parameter int DEN_W = nmc_pkg::DIV_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_W-1:0]           dividend,
   input  logic [DEN_W-1:0]           divisor,
   output logic [NUM_W-1:0]           quotient,
   output nmc_pkg::div_stat_type      stat
);

   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff <= dividend;
            den_ff <= divisor;
            rem_ff <= '0;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            num_ff <= {num_ff[NUM_W-2:0], fits};
            rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient  = num_ff;
   assign stat.run  = run_ff;
   assign stat.done = done_ff;

endmodule

/* hw/rtl/nuclear_mass_cache.sv */
// Nuclear mass cache: triangular-slot mass table with liquid-drop fallback on miss.
// Invalid nuclide or unused code answers from ST_CHECK; hit, stability or add answer from ST_DECIDE.
// Miss: ST_SUM_Z, ST_PAIR, two divider passes, a 4-step reciprocal multiply, ST_DIFF and ST_ROUND.
// One beat in flight; busy drops in its rsp_valid cycle.
// After reset the table is swept to zero, one entry a cycle, all 32896 entries by default.
// The result strobe is one cycle wide; the receiver cannot stall it.
`include "nuclear_mass_cache_defines.svh"

module nuclear_mass_cache #(
   parameter int MAX_MASS_NUMBER    = nmc_pkg::MAX_MASS_NUMBER_DEF,
   parameter int MASS_FRACTION_BITS = nmc_pkg::MASS_FRACTION_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_command,
   input  logic [7:0]                 req_atomic_mass,
   input  logic [7:0]                 req_charge_number,
   input  logic [nmc_pkg::MASS_W-1:0] req_new_mass,
   output logic                       rsp_valid,
   output logic [nmc_pkg::MASS_W-1:0] rsp_mass_out,
   output logic                       rsp_is_stable,
   output logic                       rsp_was_cached,
   output logic                       rsp_invalid
);

   localparam int DEPTH  = ((MAX_MASS_NUMBER + 1) * (MAX_MASS_NUMBER + 2)) / 2;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RND_SH = 32 - MASS_FRACTION_BITS;
   localparam logic [nmc_pkg::Q_W-1:0] RND_HALF = nmc_pkg::Q_W'(1) << (RND_SH - 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_DECIDE, ST_SUM_Z, ST_PAIR,
      ST_DIV_D, ST_DIV_C, ST_MUL_K, ST_DIFF, ST_ROUND
   } state_type;

   state_type                   state_ff, state_in;
   logic [1:0]                  cmd_ff, cmd_in;
   logic [7:0]                  a_ff, a_in;
   logic [7:0]                  z_ff, z_in;
   logic [nmc_pkg::MASS_W-1:0]  nm_ff, nm_in;
   logic [nmc_pkg::Q_W-1:0]     pos_ff, pos_in;
   logic [nmc_pkg::Q_W-1:0]     neg_ff, neg_in;
   logic [nmc_pkg::Q_W-1:0]     q_ff, q_in;
   logic [127:0]                acc_ff, acc_in;
   logic [1:0]                  step_ff, step_in;
   logic                        issued_ff, issued_in;
   logic [ADDR_W-1:0]           clr_ff, clr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [nmc_pkg::MASS_W-1:0]  rsp_mass_ff, rsp_mass_in;
   logic                        rsp_stable_ff, rsp_stable_in;
   logic                        rsp_cached_ff, rsp_cached_in;
   logic                        rsp_invalid_ff, rsp_invalid_in;

   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [nmc_pkg::ENTRY_W-1:0] wr_data;
   logic [nmc_pkg::ENTRY_W-1:0] rd_data;
   logic [ADDR_W-1:0]           slot;
   logic [16:0]                 tri_w;
   logic [16:0]                 slot_w;
   logic [7:0]                  n_idx;
   logic [8:0]                  two_z;
   logic [8:0]                  d_w;
   logic                        bad_nuc;
   logic [nmc_pkg::Q_W-1:0]     rounded;
   logic [31:0]                 mul_a;
   logic [31:0]                 mul_b;
   logic [63:0]                 mul_p;
   logic [127:0]                mul_term;
   logic [127:0]                acc_sum;

   logic                        div_start;
   logic [nmc_pkg::Q_W-1:0]     div_num;
   logic [nmc_pkg::DIV_W-1:0]   div_den;
   logic [nmc_pkg::Q_W-1:0]     div_quot;
   nmc_pkg::div_stat_type       div_stat;

   nmc_ram #(.WIDTH(nmc_pkg::ENTRY_W), .DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   nmc_div #(.NUM_W(nmc_pkg::Q_W), .DEN_W(nmc_pkg::DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   always_comb begin
      tri_w   = 17'(a_ff) * (17'(a_ff) + 17'd1);
      slot_w  = {1'b0, tri_w[16:1]} + 17'(z_ff);
      slot    = ADDR_W'(slot_w);
      n_idx   = a_ff - z_ff;
      two_z   = {z_ff, 1'b0};
      d_w     = ({1'b0, a_ff} >= two_z) ? ({1'b0, a_ff} - two_z) : (two_z - {1'b0, a_ff});
      bad_nuc = (z_ff > a_ff) || (a_ff == 8'd0) || (10'(a_ff) > 10'(MAX_MASS_NUMBER));
      rounded = (q_ff + RND_HALF) >> RND_SH;
   end

   // 64 x 64 reciprocal product, one 32 x 32 partial a step
   always_comb begin
      mul_a = step_ff[1] ? q_ff[63:32] : q_ff[31:0];
      mul_b = step_ff[0] ? nmc_pkg::COUL_RCP[63:32] : nmc_pkg::COUL_RCP[31:0];
      mul_p = 64'(mul_a) * 64'(mul_b);
      unique case (step_ff)
         2'd0:    mul_term = 128'(mul_p);
         2'd3:    mul_term = {mul_p, 64'd0};
         default: mul_term = {32'd0, mul_p, 32'd0};
      endcase
      acc_sum = acc_ff + mul_term;
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      unique case (state_ff)
         ST_DIV_D: begin
            div_start = !issued_ff;
            div_num   = nmc_pkg::DD_TAB[d_w[7:0]] << 32;
            div_den   = nmc_pkg::DIV_W'(a_ff) * nmc_pkg::SURF_DIV;
         end
         ST_DIV_C: begin
            div_start = !issued_ff;
            div_num   = nmc_pkg::NUM_Z_TAB[z_ff] << 24;
            div_den   = nmc_pkg::DIV_W'(nmc_pkg::CR_A_TAB[a_ff][nmc_pkg::CR_W-1:0]);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      a_in           = a_ff;
      z_in           = z_ff;
      nm_in          = nm_ff;
      pos_in         = pos_ff;
      neg_in         = neg_ff;
      q_in           = q_ff;
      acc_in         = acc_ff;
      step_in        = step_ff;
      issued_in      = issued_ff;
      clr_in         = clr_ff;
      rsp_valid_in   = 1'b0;
      rsp_mass_in    = rsp_mass_ff;
      rsp_stable_in  = rsp_stable_ff;
      rsp_cached_in  = rsp_cached_ff;
      rsp_invalid_in = rsp_invalid_ff;
      wr_en          = 1'b0;
      wr_addr        = slot;
      wr_data        = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_command;
               a_in     = req_atomic_mass;
               z_in     = req_charge_number;
               nm_in    = req_new_mass;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            rsp_mass_in    = '0;
            rsp_stable_in  = 1'b0;
            rsp_cached_in  = 1'b0;
            rsp_invalid_in = 1'b0;
            if (cmd_ff != nmc_pkg::CMD_MASS && cmd_ff != nmc_pkg::CMD_STAB
                && cmd_ff != nmc_pkg::CMD_ADD) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (bad_nuc) begin
               rsp_invalid_in = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            rsp_cached_in = rd_data[nmc_pkg::CACHED_B];
            rsp_stable_in = rd_data[nmc_pkg::STABLE_B];
            rsp_mass_in   = '0;
            unique case (cmd_ff)
               nmc_pkg::CMD_STAB: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
               nmc_pkg::CMD_ADD: begin
                  wr_en         = 1'b1;
                  wr_data       = {1'b1, 1'b1, nm_ff};
                  rsp_stable_in = 1'b1;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end
               default: begin
                  if (rd_data[nmc_pkg::CACHED_B]) begin
                     rsp_mass_in  = rd_data[nmc_pkg::MASS_W-1:0];
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     pos_in   = nmc_pkg::POS_A_TAB[a_ff] + nmc_pkg::POS_N_TAB[n_idx];
                     neg_in   = nmc_pkg::NEG_A_TAB[a_ff] + nmc_pkg::NEG_Z_TAB[z_ff];
                     state_in = ST_SUM_Z;
                  end
               end
            endcase
         end
         ST_SUM_Z: begin
            pos_in   = pos_ff + nmc_pkg::POS_Z_TAB[z_ff];
            state_in = ST_PAIR;
         end
         ST_PAIR: begin
            // pairing: even-even lowers, odd-odd raises
            if (!a_ff[0]) begin
               if (z_ff[0]) pos_in = pos_ff + nmc_pkg::PAIR_A_TAB[a_ff];
               else neg_in = neg_ff + nmc_pkg::PAIR_A_TAB[a_ff];
            end
            state_in = ST_DIV_D;
         end
         ST_DIV_D: begin
            if (!issued_ff) issued_in = 1'b1;
            else if (div_stat.done) begin
               issued_in = 1'b0;
               pos_in    = pos_ff + div_quot;
               state_in  = ST_DIV_C;
            end
         end
         ST_DIV_C: begin
            if (!issued_ff) issued_in = 1'b1;
            else if (div_stat.done) begin
               issued_in = 1'b0;
               q_in      = div_quot;
               acc_in    = '0;
               step_in   = '0;
               state_in  = ST_MUL_K;
            end
         end
         ST_MUL_K: begin
            acc_in  = acc_sum;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               pos_in   = pos_ff + acc_sum[nmc_pkg::COUL_SH +: nmc_pkg::Q_W];
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            q_in     = (pos_ff <= neg_ff) ? '0 : (pos_ff - neg_ff);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            wr_en         = 1'b1;
            wr_data       = {1'b1, 1'b0, rounded[nmc_pkg::MASS_W-1:0]};
            rsp_mass_in   = rounded[nmc_pkg::MASS_W-1:0];
            rsp_stable_in = 1'b0;
            rsp_cached_in = 1'b0;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      a_ff           <= a_in;
      z_ff           <= z_in;
      nm_ff          <= nm_in;
      pos_ff         <= pos_in;
      neg_ff         <= neg_in;
      q_ff           <= q_in;
      acc_ff         <= acc_in;
      step_ff        <= step_in;
      rsp_mass_ff    <= rsp_mass_in;
      rsp_stable_ff  <= rsp_stable_in;
      rsp_cached_ff  <= rsp_cached_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mass_out   = rsp_mass_ff;
   assign rsp_is_stable  = rsp_stable_ff;
   assign rsp_was_cached = rsp_cached_ff;
   assign rsp_invalid    = rsp_invalid_ff;

   `NMC_ASSERT_SAME(a_rsp_idle, rsp_valid, state_ff == ST_IDLE, "result beat outside idle")
   `NMC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
   `NMC_ASSERT_SAME(a_div_free, div_start, !div_stat.run, "divider restarted while running")
   `NMC_ASSERT_SAME(a_invalid_clean, rsp_valid && rsp_invalid,
      rsp_mass_out == '0 && !rsp_is_stable && !rsp_was_cached, "invalid beat carries data")

endmodule
